@@ rtl/gnd_pkg.sv @@
package gnd_pkg;

    localparam int AMOUNT_W  = 32;
    localparam int DENOM_W   = 16;
    localparam int COUNT_W   = 32;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KIND_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_A    = 3'd1;

    localparam logic [DENOM_W-1:0] LEFTOVER_MAX = 16'hFFFF;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ rtl/gnd_front.sv @@
module gnd_front #(
    parameter int K     = 6,
    parameter int KW    = 3,
    parameter int JOB_W = 131
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [gnd_pkg::AMOUNT_W-1:0]      amount,
    input  logic [gnd_pkg::KIND_W-1:0]        kind_count,
    input  logic [gnd_pkg::DENOM_W-1:0]       denoms [K],
    output logic                              q_push,
    input  gnd_pkg::q_stat_t                  q_stat,
    output logic [JOB_W-1:0]                  q_data
);

    localparam int RW = (K > 1) ? $clog2(K) : 1;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SORT = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                    state_reg;
    logic [RW-1:0]                 round_reg;
    logic [KW-1:0]                 n_reg;
    logic [gnd_pkg::AMOUNT_W-1:0]  amount_reg;
    logic [gnd_pkg::DENOM_W-1:0]   vals_reg [K];
    logic [gnd_pkg::DENOM_W-1:0]   sorted   [K];
    logic [KW-1:0]                 n_in;
    logic                          accept;

    assign in_stall = (state_reg != F_IDLE);
    assign accept   = in_valid && !in_stall;
    assign q_push   = (state_reg == F_PUSH) && !q_stat.full;

    always_comb
    begin
        if (kind_count == '0)
        begin
            n_in = KW'(1);
        end
        else if (int'(kind_count) > K)
        begin
            n_in = KW'(K);
        end
        else
        begin
            n_in = KW'(kind_count);
        end
    end

    // One round of odd-even transposition sort; the pairs of a round are disjoint.
    always_comb
    begin
        sorted = vals_reg;
        for (int i = 0; i < K - 1; i++)
        begin
            if ((i[0] == round_reg[0]) && (vals_reg[i+1] > vals_reg[i]))
            begin
                sorted[i]   = vals_reg[i+1];
                sorted[i+1] = vals_reg[i];
            end
        end
    end

    always_comb
    begin
        q_data = '0;
        q_data[gnd_pkg::AMOUNT_W-1:0] = amount_reg;
        for (int i = 0; i < K; i++)
        begin
            q_data[gnd_pkg::AMOUNT_W + i*gnd_pkg::DENOM_W +: gnd_pkg::DENOM_W] = vals_reg[i];
        end
        q_data[JOB_W-1 -: KW] = n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            round_reg <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_SORT;
                        round_reg <= '0;
                    end
                end
                F_SORT:
                begin
                    round_reg <= round_reg + RW'(1);
                    if (round_reg == RW'(K - 1))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_stat.full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            amount_reg <= amount;
            n_reg      <= n_in;
            for (int i = 0; i < K; i++)
            begin
                vals_reg[i] <= (i < int'(n_in)) ? denoms[i] : '0;
            end
        end
        else if (state_reg == F_SORT)
        begin
            vals_reg <= sorted;
        end
    end

endmodule

@@ rtl/gnd_queue.sv @@
module gnd_queue #(
    parameter int JOB_W = 131
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [JOB_W-1:0]  push_data,
    input  logic              pop,
    output logic [JOB_W-1:0]  pop_data,
    output gnd_pkg::q_stat_t  stat
);

    logic [JOB_W-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/gnd_back.sv @@
module gnd_back #(
    parameter int K     = 6,
    parameter int KW    = 3,
    parameter int JOB_W = 131
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          q_pop,
    input  gnd_pkg::q_stat_t              q_stat,
    input  logic [JOB_W-1:0]              q_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gnd_pkg::DENOM_W-1:0]   denomination,
    output logic [gnd_pkg::COUNT_W-1:0]   note_count,
    output logic [gnd_pkg::DENOM_W-1:0]   leftover,
    output logic                          is_last
);

    localparam int IDXW  = (K > 1) ? $clog2(K) : 1;
    localparam int STEPW = $clog2(gnd_pkg::AMOUNT_W);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_SETUP = 2'd1;
    localparam logic [1:0] B_DIV   = 2'd2;
    localparam logic [1:0] B_EMIT  = 2'd3;

    logic [1:0]                     state_reg;
    logic [IDXW-1:0]                idx_reg;
    logic [STEPW-1:0]               step_reg;
    logic [KW-1:0]                  n_reg;
    logic [gnd_pkg::DENOM_W-1:0]    vals_reg [K];
    logic [gnd_pkg::AMOUNT_W-1:0]   rem_reg;
    logic [gnd_pkg::DENOM_W-1:0]    acc_reg;
    logic [gnd_pkg::AMOUNT_W-1:0]   dvd_reg;
    logic [gnd_pkg::COUNT_W-1:0]    cnt_reg;
    logic                           out_valid_reg;
    logic [gnd_pkg::DENOM_W-1:0]    denom_out_reg;
    logic [gnd_pkg::COUNT_W-1:0]    cnt_out_reg;
    logic [gnd_pkg::DENOM_W-1:0]    left_out_reg;
    logic                           last_out_reg;

    logic [gnd_pkg::DENOM_W-1:0]    d;
    logic [gnd_pkg::DENOM_W:0]      trial;
    logic                           ge;
    logic [gnd_pkg::DENOM_W-1:0]    acc_new;
    logic [gnd_pkg::AMOUNT_W-1:0]   dvd_new;
    logic                           out_load;
    logic                           at_last;

    assign q_pop    = (state_reg == B_IDLE) && !q_stat.empty;
    assign d        = vals_reg[idx_reg];
    assign trial    = {acc_reg, dvd_reg[gnd_pkg::AMOUNT_W-1]};
    assign ge       = (trial >= {1'b0, d});
    assign acc_new  = ge ? gnd_pkg::DENOM_W'(trial - {1'b0, d})
                         : trial[gnd_pkg::DENOM_W-1:0];
    assign dvd_new  = {dvd_reg[gnd_pkg::AMOUNT_W-2:0], ge};
    assign out_load = (state_reg == B_EMIT) && (!out_valid_reg || !out_stall);
    assign at_last  = ((KW'(idx_reg) + KW'(1)) == n_reg);

    assign out_valid    = out_valid_reg;
    assign denomination = denom_out_reg;
    assign note_count   = cnt_out_reg;
    assign leftover     = left_out_reg;
    assign is_last      = last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        idx_reg   <= '0;
                        state_reg <= B_SETUP;
                    end
                end
                B_SETUP:
                begin
                    step_reg  <= '0;
                    state_reg <= (d == '0) ? B_EMIT : B_DIV;
                end
                B_DIV:
                begin
                    step_reg <= step_reg + STEPW'(1);
                    if (step_reg == STEPW'(gnd_pkg::AMOUNT_W - 1))
                    begin
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT:
                begin
                    if (out_load)
                    begin
                        if (at_last)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDXW'(1);
                            state_reg <= B_SETUP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    rem_reg <= q_data[gnd_pkg::AMOUNT_W-1:0];
                    n_reg   <= q_data[JOB_W-1 -: KW];
                    for (int i = 0; i < K; i++)
                    begin
                        vals_reg[i] <=
                            q_data[gnd_pkg::AMOUNT_W + i*gnd_pkg::DENOM_W +: gnd_pkg::DENOM_W];
                    end
                end
            end
            B_SETUP:
            begin
                acc_reg <= '0;
                dvd_reg <= rem_reg;
                cnt_reg <= '0;
            end
            B_DIV:
            begin
                acc_reg <= acc_new;
                dvd_reg <= dvd_new;
                if (step_reg == STEPW'(gnd_pkg::AMOUNT_W - 1))
                begin
                    cnt_reg <= dvd_new;
                    rem_reg <= gnd_pkg::AMOUNT_W'(acc_new);
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            denom_out_reg <= d;
            cnt_out_reg   <= cnt_reg;
            left_out_reg  <= (rem_reg > gnd_pkg::AMOUNT_W'(gnd_pkg::LEFTOVER_MAX))
                             ? gnd_pkg::LEFTOVER_MAX : rem_reg[gnd_pkg::DENOM_W-1:0];
            last_out_reg  <= at_last;
        end
    end

endmodule

@@ rtl/greedy_note_dispenser.sv @@
// Greedy note dispenser.
// The input channel (in_valid, in_stall, amount) takes one requested amount per item.
// For each item the block emits one result item per denomination in use, largest
// value first, on the output channel (out_valid, out_stall, denomination, note_count,
// leftover, is_last); is_last marks the result for the smallest value.
// Registers are written over the cfg channel: index 0 is the kind count, indexes
// 1 to 6 are the note values. They are to be written only while the block is idle;
// the block itself does not enforce this. The note values of each accepted amount
// are sorted, then handed with the amount through a two-entry queue to the divider,
// so a new amount can be taken while the previous one is still being divided.
// Each result comes from a shared restoring divider, one quotient bit per cycle;
// a zero note value skips the division. The divider works through every note value
// of an amount before it takes the next amount from the queue.
// in_stall is high after each accepted item while the front sorts it, and it stays
// high while the sorted item waits for room in the queue.
// When the receiver stalls, the result is held in the output register and the
// divider waits before the next result.
// Reset clears all handshake state and sets every register to 1.
module greedy_note_dispenser #(
    parameter int MAX_KINDS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gnd_pkg::AMOUNT_W-1:0]        amount,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gnd_pkg::DENOM_W-1:0]         denomination,
    output logic [gnd_pkg::COUNT_W-1:0]         note_count,
    output logic [gnd_pkg::DENOM_W-1:0]         leftover,
    output logic                                is_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gnd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gnd_pkg::DENOM_W-1:0]         cfg_data
);

    localparam int KW    = $clog2(MAX_KINDS + 1);
    localparam int JOB_W = gnd_pkg::AMOUNT_W + MAX_KINDS * gnd_pkg::DENOM_W + KW;

    logic [gnd_pkg::KIND_W-1:0]   kind_reg;
    logic [gnd_pkg::DENOM_W-1:0]  denom_reg [MAX_KINDS];
    logic                         q_push;
    logic                         q_pop;
    logic [JOB_W-1:0]             q_push_data;
    logic [JOB_W-1:0]             q_pop_data;
    gnd_pkg::q_stat_t             q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= gnd_pkg::KIND_W'(1);
            for (int i = 0; i < MAX_KINDS; i++)
            begin
                denom_reg[i] <= gnd_pkg::DENOM_W'(1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == gnd_pkg::REG_KIND_COUNT)
            begin
                kind_reg <= cfg_data[gnd_pkg::KIND_W-1:0];
            end
            for (int i = 0; i < MAX_KINDS; i++)
            begin
                if (cfg_index == gnd_pkg::REG_DENOM_A + gnd_pkg::CFG_IDX_W'(i))
                begin
                    denom_reg[i] <= cfg_data;
                end
            end
        end
    end

    gnd_front #(
        .K     (MAX_KINDS),
        .KW    (KW),
        .JOB_W (JOB_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .amount     (amount),
        .kind_count (kind_reg),
        .denoms     (denom_reg),
        .q_push     (q_push),
        .q_stat     (q_stat),
        .q_data     (q_push_data)
    );

    gnd_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    gnd_back #(
        .K     (MAX_KINDS),
        .KW    (KW),
        .JOB_W (JOB_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_pop        (q_pop),
        .q_stat       (q_stat),
        .q_data       (q_pop_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .denomination (denomination),
        .note_count   (note_count),
        .leftover     (leftover),
        .is_last      (is_last)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("Job pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("Job popped from an empty queue.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("Front did not go busy after taking an item.");

    a_leftover_below_denom: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (denomination != '0)) |-> (leftover < denomination))
        else $error("Leftover is not below its denomination.");
`endif

endmodule
